@@ sv/gack_pkg.sv @@
`timescale 1ns / 1ps

package gack_pkg;

   localparam int GENE_COUNT = 20;
   localparam int GENE_IDX_W = (GENE_COUNT > 1) ? $clog2(GENE_COUNT) : 1;

   localparam int VEC_W      = 20;
   localparam int CUT_W      = 5;
   localparam int ENTRY_W    = 5;
   localparam int FACTOR_W   = 8;
   localparam int ITEM_WT_W  = 8;
   localparam int ITEM_VAL_W = 24;
   localparam int LIMIT_W    = 13;
   localparam int FIT_W      = 30;
   localparam int WT_W       = 13;
   localparam int STAMP_W    = 16;
   localparam int ACT_W      = 2;

   localparam logic [LIMIT_W-1:0] WEIGHT_LIMIT_RESET = LIMIT_W'(60);
   localparam logic [FIT_W-2:0]   FIT_MAX     = '1;
   localparam logic [FIT_W-1:0]   FIT_NEG_ONE = '1;
   localparam logic [WT_W-1:0]    WT_MAX      = '1;

   localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ONE_PT  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TWO_PT  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_UNIFORM = 2'd3;

   typedef struct packed {
      logic                  valid;
      logic [ENTRY_W-1:0]    index;
      logic [ITEM_WT_W-1:0]  weight;
      logic [FACTOR_W-1:0]   factor_one;
      logic [FACTOR_W-1:0]   factor_two;
      logic [FACTOR_W-1:0]   factor_three;
   } gack_load_type;

   typedef struct packed {
      logic [ITEM_WT_W-1:0]  weight;
      logic [ITEM_VAL_W-1:0] value;
   } gack_item_type;

   typedef struct packed {
      logic start;
      logic step;
   } gack_walk_type;

endpackage

@@ sv/gack_table.sv @@
`timescale 1ns / 1ps

module gack_table import gack_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  gack_load_type         load,
   input  logic [GENE_IDX_W-1:0] rd_index,
   output gack_item_type         item
);

   logic                  pend_ff, pend_in;
   logic [ENTRY_W-1:0]    idx_ff, idx_in;
   logic [ITEM_WT_W-1:0]  wt_ff, wt_in;
   logic [15:0]           prod_ff, prod_in;
   logic [FACTOR_W-1:0]   f3_ff, f3_in;

   logic [ITEM_WT_W-1:0]  weight_tab_ff [GENE_COUNT];
   logic [ITEM_WT_W-1:0]  weight_tab_in [GENE_COUNT];
   logic [ITEM_VAL_W-1:0] value_tab_ff  [GENE_COUNT];
   logic [ITEM_VAL_W-1:0] value_tab_in  [GENE_COUNT];

   logic                  wr_en;
   logic [GENE_IDX_W-1:0] wr_idx;
   logic [ITEM_VAL_W-1:0] wr_value;

   // first stage: two factors multiplied, second stage: third factor and write
   always_comb begin
      pend_in = load.valid;
      idx_in  = load.index;
      wt_in   = load.weight;
      f3_in   = load.factor_three;
      prod_in = 16'(load.factor_one) * 16'(load.factor_two);
   end

   always_comb begin
      wr_en    = pend_ff && (32'(idx_ff) < GENE_COUNT);
      wr_idx   = GENE_IDX_W'(idx_ff);
      wr_value = ITEM_VAL_W'(prod_ff) * ITEM_VAL_W'(f3_ff);
      for (int i = 0; i < GENE_COUNT; i++) begin
         weight_tab_in[i] = weight_tab_ff[i];
         value_tab_in[i]  = value_tab_ff[i];
      end
      if (wr_en) begin
         weight_tab_in[wr_idx] = wt_ff;
         value_tab_in[wr_idx]  = wr_value;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      wt_ff   <= wt_in;
      f3_ff   <= f3_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         for (int i = 0; i < GENE_COUNT; i++) begin
            weight_tab_ff[i] <= '0;
            value_tab_ff[i]  <= '0;
         end
      end else begin
         pend_ff <= pend_in;
         for (int i = 0; i < GENE_COUNT; i++) begin
            weight_tab_ff[i] <= weight_tab_in[i];
            value_tab_ff[i]  <= value_tab_in[i];
         end
      end
   end

   assign item.weight = weight_tab_ff[rd_index];
   assign item.value  = value_tab_ff[rd_index];

endmodule

@@ sv/gack_child_acc.sv @@
`timescale 1ns / 1ps

module gack_child_acc import gack_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  gack_walk_type            walk,
   input  logic [VEC_W-1:0]         genes,
   input  gack_item_type            item,
   input  logic [LIMIT_W-1:0]       weight_limit,
   output logic signed [FIT_W-1:0]  fitness,
   output logic [WT_W-1:0]          weight
);

   logic [VEC_W-1:0]   gene_ff, gene_in;
   logic [FIT_W-2:0]   val_acc_ff, val_acc_in;
   logic [WT_W:0]      wt_acc_ff, wt_acc_in;
   logic               over;
   logic [FIT_W-1:0]   val_sum;

   // once past the limit the running sums freeze
   assign over    = wt_acc_ff > {1'b0, weight_limit};
   assign val_sum = {1'b0, val_acc_ff} + FIT_W'(item.value);

   always_comb begin
      gene_in    = gene_ff;
      val_acc_in = val_acc_ff;
      wt_acc_in  = wt_acc_ff;
      if (walk.start) begin
         gene_in    = genes;
         val_acc_in = '0;
         wt_acc_in  = '0;
      end else if (walk.step) begin
         gene_in = gene_ff >> 1;
         if (!over && gene_ff[0]) begin
            val_acc_in = (val_sum > FIT_W'(FIT_MAX)) ? FIT_MAX : val_sum[FIT_W-2:0];
            wt_acc_in  = wt_acc_ff + (WT_W+1)'(item.weight);
         end
      end
   end

   always_ff @(posedge clock) begin
      gene_ff    <= gene_in;
      val_acc_ff <= val_acc_in;
      wt_acc_ff  <= wt_acc_in;
   end

   assign fitness = over ? signed'(FIT_NEG_ONE) : signed'({1'b0, val_acc_ff});
   assign weight  = (wt_acc_ff > (WT_W+1)'(WT_MAX)) ? WT_MAX : wt_acc_ff[WT_W-1:0];

   a_frozen_when_over: assert property (@(posedge clock) disable iff (reset)
      walk.step && !walk.start && over |=> $stable(wt_acc_ff) && $stable(val_acc_ff))
      else $error("child sums moved after the weight limit was passed");

endmodule

@@ sv/ga_crossover_knapsack_eval_top.sv @@
`timescale 1ns / 1ps

// channel | signals                      | payload
// req     | req_tvalid/tready/tdata/tuser| tuser: action; tdata: load and crossover fields
// rsp     | rsp_tvalid/tready/tdata      | two children, fitness, weight, generation
// csr     | csr_wr_en/csr_wr_data        | weight_limit
//
// a load request keeps the control idle; its write passes the product register into the tables
// a crossover request is walked in ST_WALK, then held in ST_DONE: one table entry per cycle is
// scored for both children, set by the single read port walk through the item tables
// req_tready is low while a crossover is being scored or its result waits for the output slot
// the output register holds a result under rsp stall while the next request is taken
// reset clears the item tables, the control state and sets weight_limit to 60
module ga_crossover_knapsack_eval_top import gack_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // entry_index, entry_weight, value_factor_one, value_factor_two, value_factor_three,
   // parent_first, parent_second, cut_one, cut_two, swap_mask, generation_stamp, zero pad
   input  logic [127:0]         req_tdata,
   // action
   input  logic [ACT_W-1:0]     req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // child_first, child_second, fitness_first, fitness_second, weight_first,
   // weight_second, child_generation, zero pad
   output logic [143:0]         rsp_tdata,
   input  logic                 csr_wr_en,
   input  logic [LIMIT_W-1:0]   csr_wr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [GENE_IDX_W-1:0] LAST_STEP = GENE_IDX_W'(GENE_COUNT - 1);

   logic [1:0]            state_ff, state_in;
   logic [GENE_IDX_W-1:0] step_ff, step_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [143:0]          rsp_data_ff, rsp_data_in;
   logic [VEC_W-1:0]      child_a_ff, child_a_in;
   logic [VEC_W-1:0]      child_b_ff, child_b_in;
   logic [STAMP_W-1:0]    stamp_ff, stamp_in;

   logic                  req_fire;
   logic                  out_room;
   logic [ACT_W-1:0]      action;
   logic [ENTRY_W-1:0]    entry_index;
   logic [ITEM_WT_W-1:0]  entry_weight;
   logic [FACTOR_W-1:0]   factor_one, factor_two, factor_three;
   logic [VEC_W-1:0]      parent_a, parent_b, swap_mask;
   logic [CUT_W-1:0]      cut_one, cut_two, cut_lo, cut_hi;
   logic [STAMP_W-1:0]    gen_stamp;
   logic [VEC_W-1:0]      swap, pa_m, pb_m, cross_a, cross_b;
   logic                  keep;

   gack_load_type         load;
   gack_walk_type         walk;
   gack_item_type         item;
   logic signed [FIT_W-1:0] fit_a, fit_b;
   logic [WT_W-1:0]       wt_a, wt_b;

   assign action       = req_tuser;
   assign entry_index  = req_tdata[4:0];
   assign entry_weight = req_tdata[12:5];
   assign factor_one   = req_tdata[20:13];
   assign factor_two   = req_tdata[28:21];
   assign factor_three = req_tdata[36:29];
   assign parent_a     = req_tdata[56:37];
   assign parent_b     = req_tdata[76:57];
   assign cut_one      = req_tdata[81:77];
   assign cut_two      = req_tdata[86:82];
   assign swap_mask    = req_tdata[106:87];
   assign gen_stamp    = req_tdata[122:107];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_room   = !rsp_valid_ff || rsp_tready;

   // swap mask per gene; genes past GENE_COUNT are dropped
   always_comb begin
      keep   = 1'b0;
      cut_lo = (cut_one <= cut_two) ? cut_one : cut_two;
      cut_hi = (cut_one <= cut_two) ? cut_two : cut_one;
      for (int b = 0; b < VEC_W; b++) begin
         keep    = (b < GENE_COUNT);
         pa_m[b] = keep && parent_a[b];
         pb_m[b] = keep && parent_b[b];
         case (action)
            ACT_ONE_PT:  swap[b] = keep && (b >= int'(cut_one));
            ACT_TWO_PT:  swap[b] = keep && (b >= int'(cut_lo)) && (b < int'(cut_hi));
            ACT_UNIFORM: swap[b] = keep && swap_mask[b];
            default:     swap[b] = 1'b0;
         endcase
      end
      cross_a = (pa_m & ~swap) | (pb_m & swap);
      cross_b = (pb_m & ~swap) | (pa_m & swap);
   end

   always_comb begin
      load.valid        = req_fire && (action == ACT_LOAD);
      load.index        = entry_index;
      load.weight       = entry_weight;
      load.factor_one   = factor_one;
      load.factor_two   = factor_two;
      load.factor_three = factor_three;
      walk.start        = req_fire && (action != ACT_LOAD);
      walk.step         = (state_ff == ST_WALK);
   end

   gack_table u_table (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .rd_index (step_ff),
      .item     (item)
   );

   gack_child_acc u_acc_first (
      .clock        (clock),
      .reset        (reset),
      .walk         (walk),
      .genes        (cross_a),
      .item         (item),
      .weight_limit (limit_ff),
      .fitness      (fit_a),
      .weight       (wt_a)
   );

   gack_child_acc u_acc_second (
      .clock        (clock),
      .reset        (reset),
      .walk         (walk),
      .genes        (cross_b),
      .item         (item),
      .weight_limit (limit_ff),
      .fitness      (fit_b),
      .weight       (wt_b)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      child_a_in   = child_a_ff;
      child_b_in   = child_b_ff;
      stamp_in     = stamp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (walk.start) begin
               state_in   = ST_WALK;
               step_in    = '0;
               child_a_in = cross_a;
               child_b_in = cross_b;
               stamp_in   = gen_stamp;
            end
         end
         ST_WALK: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_room) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, stamp_ff, wt_b, wt_a, fit_b, fit_a,
                               child_b_ff, child_a_ff};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      child_a_ff  <= child_a_in;
      child_b_ff  <= child_b_in;
      stamp_ff    <= stamp_in;
      step_ff     <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= WEIGHT_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_start_walk: assert property (@(posedge clock) disable iff (reset)
      req_fire && (action != ACT_LOAD) |=> (state_ff == ST_WALK) && (step_ff == '0))
      else $error("crossover request did not start the gene walk");

   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && (step_ff == LAST_STEP) |=> (state_ff == ST_DONE))
      else $error("gene walk did not finish after the last entry");

   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_room |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result not moved to the output register");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && (action == ACT_LOAD) && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("load request produced a response");

endmodule
